// ----- hw/rtl/sqkd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Square-kernel deconvolver package
// Field widths, register indexes, the output gain and the word format of the
// per-pixel history memory.
// ----------------------------------------------------------------------------
package sqkd_pkg;

	// Widths of the channel fields and configuration registers.
	localparam int SAMPLE_W   = 24;
	localparam int VALUE_W    = 32;
	localparam int OS_W       = 4;
	localparam int PC_W       = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_OVERSAMPLE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 1'd1;

	// Output gain of 0.99 held in Q16, and the rounding point of the product.
	localparam int               GAIN_W    = 17;
	localparam logic [GAIN_W-1:0] GAIN_Q16 = 17'd64881;
	localparam int               GAIN_FRAC = 16;

	// Sequence tag kept with every history entry; a stale tag reads as zero.
	localparam int EPOCH_W = 8;

	typedef logic [EPOCH_W-1:0] epoch_t;

	typedef struct packed {
		epoch_t             tag;
		logic [VALUE_W-1:0] value;
	} hist_word_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sqkd_history.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Square-kernel deconvolver history store
// Single-port-write, single-port-read synchronous memory of tagged decoded
// values. Entries whose tag differs from the current sequence tag read as 0.
// ----------------------------------------------------------------------------
module sqkd_history
	import sqkd_pkg::*;
#(
	parameter int ADDR_W = 16,
	parameter int DEPTH  = 65536
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [ADDR_W-1:0]         wr_addr,
	input  hist_word_t                wr_word,
	input  logic                      rd_en,
	input  logic [ADDR_W-1:0]         rd_addr,
	input  epoch_t                    epoch,
	output logic signed [VALUE_W-1:0] rd_value
);

	hist_word_t mem [DEPTH];
	hist_word_t rd_word_s1;

	// Memory array with a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_word;
		end
		if (rd_en) begin
			rd_word_s1 <= mem[rd_addr];
		end
	end

	// Values left over from an earlier sequence count as zero.
	assign rd_value = (rd_word_s1.tag == epoch) ? signed'(rd_word_s1.value) : '0;

endmodule
`default_nettype wire

// ----- hw/rtl/square_kernel_deconvolver.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Square-kernel deconvolver
// Per-pixel recursive removal of a kernel of S plus-ones and S minus-ones
// from a stream of difference samples, with a 0.99 output gain.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the in_valid/in_ready channel frame by frame, pixel 0
//   first. Each input beat gives exactly one output beat on out_valid/out_ready.
//   The oversample and pixel_count registers are written through cfg_write,
//   cfg_index and cfg_data while no sample is in flight.
//   One sample is worked at a time: no new sample is taken until the last one
//   has left the output state, and its 2S-1 history reads go one after another
//   through the single memory read port. Then come the sum, saturate and
//   multiply states, and the result is registered in the output register.
//   A finished result waits in the output register while the next sample is
//   taken; if the receiver still stalls when that sample is done, the block
//   holds it and keeps in_ready low.
//   After reset, and on every 256th sequence start, a clearing pass writes the
//   whole history memory, one entry per cycle: MAX_PIXELS * 2^ceil(log2(2 *
//   MAX_OVERSAMPLE)) entries (65536 at the default sizes). No sample is taken
//   during the pass; configuration writes still are.
// ----------------------------------------------------------------------------
module square_kernel_deconvolver
	import sqkd_pkg::*;
#(
	parameter int MAX_PIXELS     = 4096,
	parameter int MAX_OVERSAMPLE = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample_value,
	input  logic                       sequence_start,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [VALUE_W-1:0]  decoded_value
);

	localparam int RING_LEN  = 2 * MAX_OVERSAMPLE;
	localparam int SL_W      = $clog2(RING_LEN);
	localparam int D1_W      = SL_W + 1;
	localparam int POS_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int ADDR_W    = POS_W + SL_W;
	localparam int MEM_DEPTH = MAX_PIXELS * (2 ** SL_W);
	localparam int CNT_W     = $clog2(MAX_PIXELS + 1);
	localparam int S_W       = $clog2(MAX_OVERSAMPLE + 1);
	localparam int ACC_W     = VALUE_W + 2 + SL_W;
	localparam int PROD_W    = VALUE_W + GAIN_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SUM,
		ST_SAT,
		ST_MUL,
		ST_OUT,
		ST_CLEAR
	} state_t;

	state_t                     state_q;
	logic [OS_W-1:0]            oversample_q;
	logic [PC_W-1:0]            pixel_count_q;
	logic [S_W-1:0]             s_eff;
	logic [CNT_W-1:0]           cnt_eff;
	logic [D1_W-1:0]            d_last_w;
	logic [SL_W-1:0]            d_last;
	logic [SL_W-1:0]            d_q;
	logic [SL_W-1:0]            d_rd;
	logic                       d_sub;
	logic [POS_W-1:0]           pos_q;
	logic [SL_W-1:0]            slot_q;
	logic [POS_W-1:0]           cur_pos;
	logic [SL_W-1:0]            cur_slot;
	logic [D1_W-1:0]            rd_slot_w;
	logic [SL_W-1:0]            rd_slot;
	epoch_t                     epoch_q;
	logic [ADDR_W-1:0]          clr_q;
	logic                       clr_item_q;
	logic                       in_beat;
	logic                       need_clear;
	logic                       rd_en;
	logic [ADDR_W-1:0]          rd_addr;
	logic signed [VALUE_W-1:0]  rd_value;
	logic                       rd_vld_s1;
	logic                       rd_sub_s1;
	logic                       wr_en;
	logic [ADDR_W-1:0]          wr_addr;
	hist_word_t                 wr_word;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [ACC_W-1:0]    rd_term;
	logic [ACC_W-VALUE_W:0]     acc_top;
	logic signed [VALUE_W-1:0]  y_sat;
	logic signed [VALUE_W-1:0]  y_q;
	logic signed [GAIN_W:0]     gain_s;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [PROD_W-1:0]   rounded;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oversample_q  <= OS_W'(1);
			pixel_count_q <= PC_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_OVERSAMPLE:  oversample_q  <= cfg_data[OS_W-1:0];
				REG_PIXEL_COUNT: pixel_count_q <= cfg_data[PC_W-1:0];
			endcase
		end
	end

	// Clamp the registers into their working ranges.
	always_comb begin
		if (oversample_q == '0) begin
			s_eff = S_W'(1);
		end else if (32'(oversample_q) > 32'(MAX_OVERSAMPLE)) begin
			s_eff = S_W'(MAX_OVERSAMPLE);
		end else begin
			s_eff = S_W'(oversample_q);
		end
		if (pixel_count_q == '0) begin
			cnt_eff = CNT_W'(1);
		end else if (32'(pixel_count_q) > 32'(MAX_PIXELS)) begin
			cnt_eff = CNT_W'(MAX_PIXELS);
		end else begin
			cnt_eff = CNT_W'(pixel_count_q);
		end
	end

	// The deepest look-back is 2S-1 frames.
	assign d_last_w = D1_W'({s_eff, 1'b0}) - D1_W'(1);
	assign d_last   = d_last_w[SL_W-1:0];

	assign in_ready   = (state_q == ST_IDLE);
	assign in_beat    = in_valid && in_ready;
	assign need_clear = sequence_start && (epoch_q == '1);

	// Position of the sample being read: a sequence start restarts at pixel 0.
	always_comb begin
		if (state_q == ST_IDLE) begin
			cur_pos  = sequence_start ? '0 : pos_q;
			cur_slot = sequence_start ? '0 : slot_q;
			d_rd     = SL_W'(1);
		end else begin
			cur_pos  = pos_q;
			cur_slot = slot_q;
			d_rd     = d_q;
		end
	end

	// Ring slot d frames back, wrapping below slot 0.
	always_comb begin
		if (cur_slot < d_rd) begin
			rd_slot_w = D1_W'(cur_slot) + D1_W'(RING_LEN) - D1_W'(d_rd);
		end else begin
			rd_slot_w = D1_W'(cur_slot) - D1_W'(d_rd);
		end
	end
	assign rd_slot = rd_slot_w[SL_W-1:0];
	assign d_sub   = 32'(d_rd) < 32'(s_eff);

	// Memory read and write requests.
	assign rd_en   = (in_beat && !need_clear) || (state_q == ST_READ);
	assign rd_addr = {cur_pos, rd_slot};

	always_comb begin
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_word = '0;
		end else begin
			wr_en         = (state_q == ST_SAT);
			wr_addr       = {pos_q, slot_q};
			wr_word.tag   = epoch_q;
			wr_word.value = y_sat;
		end
	end

	sqkd_history #(
		.ADDR_W (ADDR_W),
		.DEPTH  (MEM_DEPTH)
	) u_history (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_word  (wr_word),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.epoch    (epoch_q),
		.rd_value (rd_value)
	);

	// Saturate the exact sum once to 32 bits.
	assign rd_term = ACC_W'(rd_value);
	assign acc_top = acc_q[ACC_W-1:VALUE_W-1];
	always_comb begin
		if ((&acc_top) || !(|acc_top)) begin
			y_sat = acc_q[VALUE_W-1:0];
		end else if (acc_q[ACC_W-1]) begin
			y_sat = {1'b1, {(VALUE_W-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(VALUE_W-1){1'b1}}};
		end
	end

	// Gain with round to nearest, halves up.
	assign gain_s  = {1'b0, GAIN_Q16};
	assign rounded = prod_q + PROD_W'(2 ** (GAIN_FRAC - 1));

	// Sequencer: read the look-back entries, sum, write back, scale, emit; or clear the history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			clr_item_q    <= 1'b0;
			epoch_q       <= '0;
			pos_q         <= '0;
			slot_q        <= '0;
			d_q           <= '0;
			rd_vld_s1     <= 1'b0;
			out_valid     <= 1'b0;
			decoded_value <= '0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (out_valid && out_ready && (state_q != ST_OUT)) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (sequence_start) begin
							pos_q  <= '0;
							slot_q <= '0;
						end
						if (need_clear) begin
							clr_q      <= '0;
							clr_item_q <= 1'b1;
							state_q    <= ST_CLEAR;
						end else begin
							if (sequence_start) begin
								epoch_q <= epoch_q + EPOCH_W'(1);
							end
							d_q     <= SL_W'(2);
							state_q <= (d_last == SL_W'(1)) ? ST_SUM : ST_READ;
						end
					end
				end
				ST_READ: begin
					d_q <= d_q + SL_W'(1);
					if (d_q == d_last) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					if (32'(pos_q) + 32'd1 >= 32'(cnt_eff)) begin
						pos_q  <= '0;
						slot_q <= (slot_q == SL_W'(RING_LEN - 1)) ? '0 : slot_q + SL_W'(1);
					end else begin
						pos_q <= pos_q + POS_W'(1);
					end
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid     <= 1'b1;
						decoded_value <= rounded[VALUE_W+GAIN_FRAC-1:GAIN_FRAC];
						state_q       <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(MEM_DEPTH - 1)) begin
						epoch_q <= '0;
						if (clr_item_q) begin
							clr_item_q <= 1'b0;
							d_q        <= SL_W'(1);
							state_q    <= ST_READ;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: accumulator, saturated value and scaled product.
	always_ff @(posedge clk) begin
		rd_sub_s1 <= d_sub;
		if (in_beat) begin
			acc_q <= ACC_W'(sample_value);
		end else if (rd_vld_s1) begin
			acc_q <= rd_sub_s1 ? acc_q - rd_term : acc_q + rd_term;
		end
		if (state_q == ST_SAT) begin
			y_q <= y_sat;
		end
		if (state_q == ST_MUL) begin
			prod_q <= y_q * gain_s;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/sqkd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Square-kernel deconvolver port checker
// Watches the channels of the top level: beat bookkeeping and output hold.
// ----------------------------------------------------------------------------
module sqkd_checker
	import sqkd_pkg::*;
(
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	input  wire                       in_ready,
	input  wire                       out_valid,
	input  wire                       out_ready,
	input  wire signed [VALUE_W-1:0]  decoded_value
);

	logic [1:0] pend_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// Count of input beats whose result has not yet left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_beat) - 2'(out_beat);
		end
	end

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(decoded_value))
		else $error("output beat dropped or changed while stalled");

	// Only one sample is worked at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !in_ready)
		else $error("input taken again straight after a beat");

	// No result appears without an input beat behind it.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("output beat without a pending input");

	// At most one result waiting and one sample in work.
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |-> pend_q != 2'd2 && pend_q != 2'd3)
		else $error("input taken with two results outstanding");

endmodule

bind square_kernel_deconvolver sqkd_checker u_sqkd_checker (.*);
`default_nettype wire
